// ----- sv/csv_record_parser_macros.svh -----
// Assertion macros shared by the parser checker.
`ifndef CSV_RECORD_PARSER_MACROS_SVH
`define CSV_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CSVP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CSVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/csvp_pkg.sv -----
// Types and constants for the CSV record parser.
package csvp_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_EOI  = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        QM_PLAIN   = 2'd0,
        QM_QUOTED  = 2'd1,
        QM_PENDING = 2'd2
    } qmode_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       present;
        kind_t      kind;
        logic [7:0] data;
    } result_t;

endpackage

// ----- sv/csvp_in_reg.sv -----
// Input register stage: holds one request until the parser step takes it.
module csvp_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_func,
    input  logic [7:0]     s_in_byte,
    input  logic           advance,
    output logic           item_valid,
    output csvp_pkg::item_t item
);
    import csvp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next     = 1'b1;
            item_next.func = s_func;
            item_next.data = s_in_byte;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/csvp_core.sv -----
// Parser state and the per-request step: quote mode, CR mark, field and record flags.
module csvp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  csvp_pkg::item_t   item,
    output csvp_pkg::result_t result
);
    import csvp_pkg::*;

    qmode_t qm_reg,  qm_next;
    logic   acr_reg, acr_next;
    logic   fhb_reg, fhb_next;
    logic   rhf_reg, rhf_next;
    logic   plain;

    always_comb begin
        qm_next        = qm_reg;
        acr_next       = acr_reg;
        fhb_next       = fhb_reg;
        rhf_next       = rhf_reg;
        plain          = 1'b0;
        result.present = 1'b0;
        result.kind    = KIND_DATA;
        result.data    = 8'd0;

        if (item.func == FUNC_EOI) begin
            if (qm_reg == QM_QUOTED) begin
                result.present = 1'b1;
                result.kind    = KIND_ERROR;
            end else if (fhb_reg || rhf_reg) begin
                result.present = 1'b1;
                result.kind    = KIND_RECORD;
            end
            qm_next  = QM_PLAIN;
            acr_next = 1'b0;
            fhb_next = 1'b0;
            rhf_next = 1'b0;
        end else begin
            acr_next = 1'b0;
            // Swallow LF right after a record-ending CR.
            if (!(acr_reg && item.data == CH_LF)) begin
                case (qm_reg)
                    QM_QUOTED: begin
                        if (item.data == CH_QUOTE) begin
                            qm_next = QM_PENDING;
                        end else begin
                            fhb_next       = 1'b1;
                            result.present = 1'b1;
                            result.data    = item.data;
                        end
                    end
                    QM_PENDING: begin
                        if (item.data == CH_QUOTE) begin
                            qm_next        = QM_QUOTED;
                            fhb_next       = 1'b1;
                            result.present = 1'b1;
                            result.data    = CH_QUOTE;
                        end else begin
                            plain = 1'b1;
                        end
                    end
                    default: begin
                        plain = 1'b1;
                    end
                endcase

                if (plain) begin
                    qm_next = QM_PLAIN;
                    case (item.data)
                        CH_QUOTE: begin
                            qm_next = QM_QUOTED;
                        end
                        CH_COMMA: begin
                            fhb_next       = 1'b0;
                            rhf_next       = 1'b1;
                            result.present = 1'b1;
                            result.kind    = KIND_FIELD;
                        end
                        CH_LF, CH_CR: begin
                            acr_next       = (item.data == CH_CR);
                            fhb_next       = 1'b0;
                            rhf_next       = 1'b0;
                            result.present = 1'b1;
                            result.kind    = KIND_RECORD;
                        end
                        default: begin
                            fhb_next       = 1'b1;
                            result.present = 1'b1;
                            result.data    = item.data;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qm_reg  <= QM_PLAIN;
            acr_reg <= 1'b0;
            fhb_reg <= 1'b0;
            rhf_reg <= 1'b0;
        end else if (step_en) begin
            qm_reg  <= qm_next;
            acr_reg <= acr_next;
            fhb_reg <= fhb_next;
            rhf_reg <= rhf_next;
        end
    end

endmodule

// ----- sv/csvp_out_reg.sv -----
// Result register: holds one result until the sink takes it.
module csvp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  csvp_pkg::result_t result,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_out_kind,
    output logic [7:0]        m_out_byte
);
    import csvp_pkg::*;

    logic       valid_reg, valid_next;
    kind_t      kind_reg,  kind_next;
    logic [7:0] byte_reg,  byte_next;

    always_comb begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        if (load) begin
            valid_next = 1'b1;
            kind_next  = result.kind;
            byte_next  = result.data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
    end

    assign m_valid    = valid_reg;
    assign m_out_kind = kind_reg;
    assign m_out_byte = byte_reg;

endmodule

// ----- sv/csv_record_parser.sv -----
// Top level of the streaming CSV field and record parser.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_func, s_in_byte
//  m_      | out       | m_valid / m_ready | m_out_kind, m_out_byte
//
// One request per cycle while results drain; a result passes both registers in turn.
// The step from input register to result register is one pass of the state logic.
// Reset (aresetn low, synchronous) empties both registers and clears the parser state.
// A stalled result holds; the input register still takes a request behind it.
module csv_record_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_out_byte
);
    import csvp_pkg::*;

    logic    item_valid;
    item_t   item;
    result_t result;
    logic    advance;

    // Advance the held request when the result register is free or draining.
    assign advance = item_valid && (!m_valid || m_ready);

    csvp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_in_byte  (s_in_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    csvp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item),
        .result  (result)
    );

    csvp_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && result.present),
        .result     (result),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_kind (m_out_kind),
        .m_out_byte (m_out_byte)
    );

endmodule

// ----- sv/csvp_checker.sv -----
// Port-level checker for the CSV record parser, bound to the top level.
`include "csv_record_parser_macros.svh"

module csvp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_out_kind,
    input logic [7:0] m_out_byte
);
    import csvp_pkg::*;

    // Hold a stalled result.
    `CSVP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_out_kind) && $stable(m_out_byte), "stalled result changed")

    // Non-data kinds carry a zero byte.
    `CSVP_ASSERT_NOW(a_zero_byte, aclk, aresetn, m_valid && (m_out_kind != KIND_DATA),
        m_out_byte == 8'd0, "non-data result with nonzero byte")

    // A result after an empty output comes from a request taken into the input register.
    `CSVP_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_valid),
        $past(s_valid && s_ready, 2), "result without a request taken two edges earlier")

endmodule

bind csv_record_parser csvp_checker u_csvp_checker (.*);
